[hw/rtl/ohlc_bar_aggregator_unit_assert.svh]
// Assertion macros for the OHLC bar aggregator.
`ifndef OHLC_BAR_AGGREGATOR_UNIT_ASSERT_SVH
`define OHLC_BAR_AGGREGATOR_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define OHLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define OHLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ohlc_pkg.sv]
// Shared types and constants of the OHLC bar aggregator.
`timescale 1ns / 1ps

package ohlc_pkg;

  // Default parameter values
  localparam int NUM_SECURITIES_DEF   = 256;
  localparam int SECONDS_PER_UNIT_DEF = 60;

  // Field geometry
  localparam int ID_SPAN    = 256;
  localparam int GRAN_MAX   = 2047;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;
  localparam int MS_W       = 27;
  localparam int GRAN_W     = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAN      = 2'd2;

  // Configuration reset values
  localparam logic [MS_W-1:0]   WIN_START_RST = 27'd0;
  localparam logic [MS_W-1:0]   WIN_END_RST   = 27'd86399999;
  localparam logic [GRAN_W-1:0] GRAN_RST      = 11'd1;

  // Item modes
  localparam logic [1:0] MODE_TRADE = 2'd0;
  localparam logic [1:0] MODE_INDEX = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  // Absent quote, -1000.0000 in four-decimal fixed point
  localparam logic signed [31:0] QUOTE_ABSENT = -32'sd10000000;

  typedef struct packed {
    logic        [1:0]      mode;
    logic        [7:0]      security_id;
    logic        [31:0]     time_sec;
    logic        [MS_W-1:0] msecs_of_day;
    logic signed [31:0]     price;
    logic        [30:0]     trade_size;
    logic signed [31:0]     best_ask;
    logic signed [31:0]     best_bid;
  } ohlc_in_t;

  typedef struct packed {
    logic        [7:0]  bar_security;
    logic        [31:0] bar_start;
    logic        [31:0] first_tick_time;
    logic        [31:0] last_tick_time;
    logic signed [31:0] open_price;
    logic signed [31:0] high_price;
    logic signed [31:0] low_price;
    logic signed [31:0] close_price;
    logic        [47:0] bar_volume;
    logic        [31:0] tick_count;
    logic signed [31:0] ask_out;
    logic signed [31:0] bid_out;
  } ohlc_out_t;

  // One stored bar per security
  typedef struct packed {
    logic        [31:0] bar_start;
    logic        [31:0] first_time;
    logic        [31:0] last_time;
    logic signed [31:0] open_p;
    logic signed [31:0] high_p;
    logic signed [31:0] low_p;
    logic signed [31:0] close_p;
    logic        [47:0] volume;
    logic        [31:0] count;
    logic signed [31:0] ask;
    logic signed [31:0] bid;
  } ohlc_bar_t;

endpackage

[hw/rtl/ohlc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps

module ohlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/ohlc_divider.sv]
// Iterative restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps

module ohlc_divider #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W-1:0] rem_nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/ohlc_bar_aggregator_unit.sv]
// Top level of the OHLC time-bar aggregator.
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one trade, index tick or
//   flush transaction at a time; in_stall is high while an item is in work.
//   Output channel (out_valid / out_stall / out_data) carries completed bars
//   from an output register, so the next item is taken while a bar waits.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   window start, window end and bar length; write only while idle.
// Timing:
//   A trade or index tick inside the window goes through the check, the
//   32-step bit-serial remainder unit that aligns time to the bar length,
//   the align step and the update; its bar, if any, is loaded into the
//   output register in the update step. A flush goes through the check and the
//   flush step; other items and items for unknown securities end at the check.
//   When a bar must be emitted while the output register is still held by
//   out_stall, the update waits until the register frees.
// Reset:
//   Synchronous, active low; every bar reads as empty afterwards and the
//   configuration returns to its defaults. in_stall is high during reset.
`timescale 1ns / 1ps
`include "ohlc_bar_aggregator_unit_assert.svh"

module ohlc_bar_aggregator_unit #(
  parameter int NUM_SECURITIES   = ohlc_pkg::NUM_SECURITIES_DEF,
  parameter int SECONDS_PER_UNIT = ohlc_pkg::SECONDS_PER_UNIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ohlc_pkg::ohlc_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ohlc_pkg::ohlc_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ohlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ohlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH   = (NUM_SECURITIES < ohlc_pkg::ID_SPAN) ?
                           NUM_SECURITIES : ohlc_pkg::ID_SPAN;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_MAX = ohlc_pkg::GRAN_MAX * SECONDS_PER_UNIT;
  localparam int LEN_W   = $clog2(LEN_MAX + 1);
  localparam int BAR_W   = $bits(ohlc_pkg::ohlc_bar_t);
  localparam logic [LEN_W-1:0] SPU_C = LEN_W'(SECONDS_PER_UNIT);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_ALIGN = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  ohlc_pkg::ohlc_in_t            item_r;
  logic [LEN_W-1:0]              len_r;
  logic [31:0]                   start_r;
  logic [DEPTH-1:0]              valid_r;
  logic                          valid_rd_r;
  logic                          out_valid_r;
  ohlc_pkg::ohlc_out_t           out_data_r;
  logic [ohlc_pkg::MS_W-1:0]     win_start_r;
  logic [ohlc_pkg::MS_W-1:0]     win_end_r;
  logic [ohlc_pkg::GRAN_W-1:0]   gran_r;

  logic                          in_accept;
  logic                          in_range;
  logic                          is_trade;
  logic                          is_tick;
  logic                          in_win;
  logic [AW-1:0]                 addr;
  logic [ohlc_pkg::GRAN_W-1:0]   gran_eff;
  logic                          div_start;
  logic                          div_done;
  logic [LEN_W-1:0]              div_rem;
  logic                          ram_rd_en;
  logic                          ram_wr_en;
  logic [BAR_W-1:0]              ram_rd_data;
  ohlc_pkg::ohlc_bar_t           bar_rd;
  ohlc_pkg::ohlc_bar_t           bar_wr;
  logic [31:0]                   stored_start;
  logic                          new_bar;
  logic                          emit_upd;
  logic                          emit_flush;
  logic                          out_free;
  logic                          out_load;
  logic signed [31:0]            new_ask;
  logic signed [31:0]            new_bid;
  logic [47:0]                   size_eff;
  logic [48:0]                   vol_sum;

  // Handshakes
  assign in_stall  = (state_r != S_IDLE) | ~rst_n;
  assign cfg_ready = rst_n;
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  // Item decode
  assign in_range = 32'(item_r.security_id) < NUM_SECURITIES;
  assign is_trade = item_r.mode == ohlc_pkg::MODE_TRADE;
  assign is_tick  = is_trade || (item_r.mode == ohlc_pkg::MODE_INDEX);
  assign in_win   = (item_r.msecs_of_day >= win_start_r) &&
                    (is_trade ? (item_r.msecs_of_day <= win_end_r)
                              : (item_r.msecs_of_day < win_end_r));
  assign addr     = AW'(item_r.security_id);
  assign gran_eff = (gran_r == '0) ? ohlc_pkg::GRAN_W'(1) : gran_r;

  // Stored bar as read
  assign bar_rd       = ohlc_pkg::ohlc_bar_t'(ram_rd_data);
  assign stored_start = valid_rd_r ? bar_rd.bar_start : 32'd0;
  assign new_bar      = start_r != stored_start;
  assign emit_upd     = new_bar && (stored_start != 32'd0);
  assign emit_flush   = stored_start != 32'd0;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!in_range) begin
          state_nxt = S_IDLE;
        end else if (item_r.mode == ohlc_pkg::MODE_FLUSH) begin
          state_nxt = S_FLUSH;
        end else if (is_tick && in_win) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!emit_flush || out_free) state_nxt = S_IDLE;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_ALIGN;
      end
      S_ALIGN: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!emit_upd || out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ram_rd_en = (state_r == S_CHECK) && in_range;
  assign div_start = (state_r == S_CHECK) && in_range && is_tick && in_win;
  assign ram_wr_en = (state_r == S_UPD) && (!emit_upd || out_free);
  assign out_load  = ((state_r == S_FLUSH) && emit_flush && out_free) ||
                     (ram_wr_en && emit_upd);

  // Quotes and volume for this tick
  always_comb begin
    if (is_trade) begin
      new_ask  = (item_r.best_ask != ohlc_pkg::QUOTE_ABSENT) ? item_r.best_ask : item_r.price;
      new_bid  = (item_r.best_bid != ohlc_pkg::QUOTE_ABSENT) ? item_r.best_bid : item_r.price;
      size_eff = 48'(item_r.trade_size);
    end else begin
      new_ask  = ohlc_pkg::QUOTE_ABSENT;
      new_bid  = ohlc_pkg::QUOTE_ABSENT;
      size_eff = '0;
    end
    vol_sum = {1'b0, bar_rd.volume} + {1'b0, size_eff};
  end

  // Restart or extend the bar
  always_comb begin
    bar_wr           = bar_rd;
    bar_wr.last_time = item_r.time_sec;
    bar_wr.ask       = new_ask;
    bar_wr.bid       = new_bid;
    bar_wr.close_p   = item_r.price;
    if (new_bar) begin
      bar_wr.bar_start  = start_r;
      bar_wr.first_time = item_r.time_sec;
      bar_wr.open_p     = item_r.price;
      bar_wr.high_p     = item_r.price;
      bar_wr.low_p      = item_r.price;
      bar_wr.volume     = size_eff;
      bar_wr.count      = 32'd1;
    end else begin
      priority if ($signed(item_r.price) > $signed(bar_rd.high_p)) begin
        bar_wr.high_p = item_r.price;
      end else if ($signed(item_r.price) < $signed(bar_rd.low_p)) begin
        bar_wr.low_p = item_r.price;
      end else begin
        // price within the range: keep high and low
      end
      bar_wr.volume = vol_sum[48] ? '1 : vol_sum[47:0];
      bar_wr.count  = (bar_rd.count == '1) ? bar_rd.count : bar_rd.count + 32'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= ohlc_pkg::WIN_START_RST;
      win_end_r   <= ohlc_pkg::WIN_END_RST;
      gran_r      <= ohlc_pkg::GRAN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ohlc_pkg::CFG_WIN_START: win_start_r <= cfg_data;
        ohlc_pkg::CFG_WIN_END:   win_end_r   <= cfg_data;
        ohlc_pkg::CFG_GRAN:      gran_r      <= cfg_data[ohlc_pkg::GRAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers: item, bar length, aligned start, read valid, result
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
      len_r  <= LEN_W'(gran_eff) * SPU_C;
    end
    if (ram_rd_en) begin
      valid_rd_r <= valid_r[addr];
    end
    if (state_r == S_ALIGN) begin
      start_r <= item_r.time_sec - 32'(div_rem);
    end
    if (out_load) begin
      out_data_r.bar_security    <= item_r.security_id;
      out_data_r.bar_start       <= stored_start;
      out_data_r.first_tick_time <= bar_rd.first_time;
      out_data_r.last_tick_time  <= bar_rd.last_time;
      out_data_r.open_price      <= bar_rd.open_p;
      out_data_r.high_price      <= bar_rd.high_p;
      out_data_r.low_price       <= bar_rd.low_p;
      out_data_r.close_price     <= bar_rd.close_p;
      out_data_r.bar_volume      <= bar_rd.volume;
      out_data_r.tick_count      <= bar_rd.count;
      out_data_r.ask_out         <= bar_rd.ask;
      out_data_r.bid_out         <= bar_rd.bid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Time alignment: remainder of time by bar length
  ohlc_divider #(
    .DVD_W (32),
    .DVS_W (LEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (item_r.time_sec),
    .divisor   (len_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Bar store, one record per security
  ohlc_ram #(
    .WIDTH (BAR_W),
    .DEPTH (DEPTH)
  ) u_bar_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (addr),
    .wr_data (BAR_W'(bar_wr)),
    .rd_en   (ram_rd_en),
    .rd_addr (addr),
    .rd_data (ram_rd_data)
  );

  // Assertions
  `OHLC_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, div_done, state_r == S_DIV, "done outside wait")
  `OHLC_ASSERT_NXT(a_emit_shows, clk, rst_n, ram_wr_en && emit_upd, out_valid_r, "bar not shown")
  `OHLC_ASSERT_NXT(a_idle_holds, clk, rst_n, !in_stall && !in_valid, state_r == S_IDLE, "left idle")

endmodule
